FILE: hdl/cobsd_pkg.sv
// Shared types and constants for the COBS stream decoder.
// No dependencies; every other file in hdl/ imports this package.
`timescale 1ns / 1ps
`default_nettype none

package cobsd_pkg;

	localparam logic [7:0] CODE_FULL = 8'hFF;
	localparam int QueueDepth = 4;
	localparam int QueueAw = $clog2(QueueDepth);

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_PROTO = 2'd1,
		STAT_OVER  = 2'd2
	} status_t;

	typedef struct packed {
		logic [7:0] enc_byte;
		logic       frame_end;
	} in_word_t;

	typedef struct packed {
		logic [7:0]  dec_byte;
		logic        has_byte;
		logic        frame_done;
		status_t     status;
		logic [15:0] decoded_len;
	} out_word_t;

	// Everything one encoded byte produces: an optional data byte, then an
	// optional frame close. Both share the same running length.
	typedef struct packed {
		logic        has_byte;
		logic [7:0]  dec_byte;
		logic        close;
		status_t     status;
		logic [15:0] len;
	} entry_t;

endpackage

`default_nettype wire

FILE: hdl/cobsd_front.sv
// Front end: accepts encoded words, tracks block state and classifies each
// word into a queue entry. Depends on cobsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cobsd_front import cobsd_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	input  wire logic [15:0] cfg_data,
	input  wire logic        in_valid,
	input  wire in_word_t    in_data,
	input  wire logic        ent_ready,
	output logic             ent_valid,
	output entry_t           ent_data
);

	logic [15:0] capacity_q;
	logic [7:0]  block_left_q;
	logic        block_full_q;
	logic        zero_owed_q;
	logic [15:0] out_count_q;
	logic        discarding_q;

	logic [7:0]  block_left_d;
	logic        block_full_d;
	logic        zero_owed_d;
	logic [15:0] out_count_d;
	logic        discarding_d;
	logic        closed;
	entry_t      ent;

	always_comb begin
		block_left_d = block_left_q;
		block_full_d = block_full_q;
		zero_owed_d  = zero_owed_q;
		out_count_d  = out_count_q;
		discarding_d = discarding_q;
		closed       = 1'b0;
		ent          = '0;
		ent.status   = STAT_OK;

		if (discarding_q) begin
			if (in_data.frame_end) begin
				discarding_d = 1'b0;
			end
		end else if (block_left_q == 8'd0) begin
			// Code word; a pending zero from the previous block goes out first.
			if (zero_owed_q) begin
				if (out_count_q >= capacity_q) begin
					closed     = 1'b1;
					ent.status = STAT_OVER;
				end else begin
					out_count_d  = out_count_q + 16'd1;
					zero_owed_d  = 1'b0;
					ent.has_byte = 1'b1;
				end
			end
			if (!closed) begin
				if (in_data.enc_byte == 8'd0) begin
					closed     = 1'b1;
					ent.status = STAT_PROTO;
				end else begin
					block_left_d = in_data.enc_byte - 8'd1;
					block_full_d = (in_data.enc_byte == CODE_FULL);
					if (in_data.enc_byte == 8'd1) begin
						zero_owed_d = 1'b1;
					end
				end
			end
		end else begin
			if (out_count_q >= capacity_q) begin
				closed     = 1'b1;
				ent.status = STAT_OVER;
			end else begin
				out_count_d  = out_count_q + 16'd1;
				block_left_d = block_left_q - 8'd1;
				if (block_left_q == 8'd1) begin
					zero_owed_d = !block_full_q;
				end
				ent.has_byte = 1'b1;
				ent.dec_byte = in_data.enc_byte;
			end
		end

		if (!discarding_q && !closed && in_data.frame_end) begin
			closed     = 1'b1;
			ent.status = (block_left_d != 8'd0) ? STAT_PROTO : STAT_OK;
		end

		ent.close = closed;
		ent.len   = out_count_d;

		if (closed) begin
			block_left_d = 8'd0;
			block_full_d = 1'b0;
			zero_owed_d  = 1'b0;
			out_count_d  = 16'd0;
			discarding_d = (ent.status != STAT_OK) && !in_data.frame_end;
		end
	end

	assign ent_valid = in_valid && (ent.has_byte || ent.close);
	assign ent_data  = ent;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q   <= 16'hFFFF;
			block_left_q <= 8'd0;
			block_full_q <= 1'b0;
			zero_owed_q  <= 1'b0;
			out_count_q  <= 16'd0;
			discarding_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				capacity_q <= cfg_data;
			end
			if (in_valid && ent_ready) begin
				block_left_q <= block_left_d;
				block_full_q <= block_full_d;
				zero_owed_q  <= zero_owed_d;
				out_count_q  <= out_count_d;
				discarding_q <= discarding_d;
			end
		end
	end

endmodule

`default_nettype wire

FILE: hdl/cobsd_queue.sv
// Short first-word-fall-through queue of entries between front and back.
// Depends on cobsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cobsd_queue import cobsd_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push,
	input  wire entry_t push_data,
	output logic        not_full,
	input  wire logic   pop,
	output logic        not_empty,
	output entry_t      head
);

	entry_t               mem [QueueDepth];
	logic [QueueAw-1:0]   wr_ptr_q;
	logic [QueueAw-1:0]   rd_ptr_q;
	logic [QueueAw:0]     count_q;

	assign not_full  = (count_q != QueueAw'(0) + (QueueAw+1)'(QueueDepth));
	assign not_empty = (count_q != '0);
	assign head      = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && not_full) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push && not_full) begin
				wr_ptr_q <= wr_ptr_q + QueueAw'(1);
			end
			if (pop && not_empty) begin
				rd_ptr_q <= rd_ptr_q + QueueAw'(1);
			end
			case ({push && not_full, pop && not_empty})
				2'b10:   count_q <= count_q + (QueueAw+1)'(1);
				2'b01:   count_q <= count_q - (QueueAw+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: hdl/cobsd_back.sv
// Back end: turns each queued entry into one or two output words, the data
// byte first and the frame close second. Depends on cobsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cobsd_back import cobsd_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   q_not_empty,
	input  wire entry_t q_head,
	output logic        q_pop,
	output logic        out_valid,
	input  wire logic   out_ready,
	output out_word_t   out_data
);

	// Set once the byte half of an entry that also closes a frame is sent.
	logic byte_sent_q;
	logic byte_part;

	assign byte_part = q_head.has_byte && !byte_sent_q;
	assign out_valid = q_not_empty;

	always_comb begin
		out_data.decoded_len = q_head.len;
		if (byte_part) begin
			out_data.dec_byte   = q_head.dec_byte;
			out_data.has_byte   = 1'b1;
			out_data.frame_done = 1'b0;
			out_data.status     = STAT_OK;
		end else begin
			out_data.dec_byte   = 8'd0;
			out_data.has_byte   = 1'b0;
			out_data.frame_done = 1'b1;
			out_data.status     = q_head.status;
		end
	end

	assign q_pop = q_not_empty && out_ready && !(byte_part && q_head.close);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_sent_q <= 1'b0;
		end else if (q_not_empty && out_ready) begin
			byte_sent_q <= byte_part && q_head.close;
		end
	end

endmodule

`default_nettype wire

FILE: hdl/cobs_stream_decoder.sv
// Top level of the COBS stream decoder: front end, entry queue, back end.
// Depends on cobsd_pkg, cobsd_front, cobsd_queue and cobsd_back.
//
//   channel   direction  handshake             payload
//   cfg       in         cfg_valid/cfg_ready   cfg_data (out_capacity)
//   in        in         in_valid/in_ready     in_data  (in_word_t)
//   out       out        out_valid/out_ready   out_data (out_word_t)
//
// One encoded word is taken per cycle whenever the four-entry queue has room;
// the front end's block and length update closes in that cycle.
// Each word yields zero, one or two output words; the back end sends one per
// cycle while out_ready is high, so a word with a byte and a close gives two words.
// Reset restores out_capacity to 65535 and starts a fresh frame.
// Output stalls back up only through the queue; cfg_ready is always high.
`timescale 1ns / 1ps
`default_nettype none

module cobs_stream_decoder import cobsd_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [15:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire in_word_t    in_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output out_word_t        out_data
);

	logic   ent_valid;
	entry_t ent_data;
	logic   q_not_full;
	logic   q_not_empty;
	logic   q_pop;
	entry_t q_head;

	assign cfg_ready = 1'b1;
	assign in_ready  = q_not_full;

	cobsd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_data   (in_data),
		.ent_ready (q_not_full),
		.ent_valid (ent_valid),
		.ent_data  (ent_data)
	);

	cobsd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (ent_valid),
		.push_data (ent_data),
		.not_full  (q_not_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	cobsd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data)
	);

endmodule

`default_nettype wire
